// ===== rtl/core/bytecode_instruction_decoder_core_macros.svh =====
// Assertion helpers shared by the decoder core.
// Both sample on the rising clock edge and are off while reset is held.
`ifndef BYTECODE_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define BYTECODE_INSTRUCTION_DECODER_CORE_MACROS_SVH

// A plain property that must hold at every edge.
`define BID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication: when the antecedent holds, the consequent holds in the next cycle.
`define BID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bid_pkg.sv =====
package bid_pkg;

  // Opcode map limits and the two opcodes with special meaning.
  localparam logic [7:0] OpcodeCount = 8'd60;
  localparam logic [7:0] OpcConst    = 8'd8;
  localparam logic [7:0] OpcJump     = 8'd10;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadOp   = 2'd1,
    StPastEnd = 2'd2
  } bid_status_e;

  // One decoded result.
  typedef struct packed {
    logic [7:0]         opcode;
    logic signed [31:0] imm_value;
    logic signed [15:0] depth_before;
    logic [19:0]        instr_index;
    bid_status_e        status;
    logic               final_res;
  } bid_result_t;

  // Number of immediate bytes that follow an opcode.
  function automatic logic [2:0] imm_len(input logic [7:0] opc);
    logic [2:0] len;
    case (opc) inside
      8'd3, 8'd4, 8'd8, 8'd9, [8'd11:8'd26], 8'd34: len = 3'd4;
      8'd33:                                        len = 3'd1;
      default:                                      len = 3'd0;
    endcase
    return len;
  endfunction

  // Operand stack change in bytes caused by an opcode.
  function automatic logic signed [3:0] stack_delta(input logic [7:0] opc);
    logic signed [3:0] d;
    case (opc) inside
      8'd6, 8'd8, 8'd9:                               d = 4'sd4;
      8'd4, 8'd7, 8'd10, 8'd33, [8'd38:8'd48],
      [8'd50:8'd52], [8'd54:8'd57]:                   d = -4'sd4;
      [8'd11:8'd26], [8'd30:8'd32], 8'd34:            d = -4'sd8;
      default:                                        d = 4'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/bytecode_instruction_decoder_core.sv =====
// Stack-machine bytecode decoder core.
// The code segment enters one byte per request on the s_axis channel. Each
// finished instruction, and each error, leaves as one request on m_axis:
// tdata carries opcode, immediate, depth before and instruction index,
// tuser the status, and tlast is set on the last instruction or an error.
// The cfg port writes instruction_total (index 0) and code_bytes (index 1);
// the user must write them only while the stream is idle; the block does not enforce this.
// Throughput is one code byte per cycle while m_axis takes its results; the
// input register, the decode logic and the result register form a two-stage
// path, and a result is held in the result register once its last byte leaves decode.
// A stalled m_axis holds its result; the decode stage then stops and the
// input register takes at most one more byte before s_axis_tready_o drops.
// Reset clears all decoder state and the valid flags of both registers,
// so nothing is decoded until instruction_total is written. After an
// error every byte is dropped until the next reset.
module bytecode_instruction_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] code_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] opcode, [39:8] imm_value, [55:40] depth_before, [75:56] instr_index, [79:76] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // [1:0] status
  output logic        m_axis_tlast_o
);
  import bid_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        adv;
  logic        res_valid;
  bid_result_t res;
  bid_result_t out_res;

  bid_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  bid_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (in_valid),
    .byte_i      (in_byte),
    .adv_i       (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bid_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_i     (m_axis_tready_i),
    .adv_o       (adv),
    .valid_o     (m_axis_tvalid_o),
    .res_o       (out_res)
  );

  // Pack the result onto the stream.
  assign m_axis_tdata_o = {4'd0, out_res.instr_index, out_res.depth_before,
                           out_res.imm_value, out_res.opcode};
  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tlast_o = out_res.final_res;

endmodule

// ===== rtl/core/bid_in_reg.sv =====
module bid_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The register frees up whenever its request moves on to decode.
  assign ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/bid_decode.sv =====
`include "bytecode_instruction_decoder_core_macros.svh"

module bid_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 adv_i,
  output logic                 res_valid_o,
  output bid_pkg::bid_result_t res_o
);
  import bid_pkg::*;

  localparam logic CfgTotal = 1'b0;
  localparam logic CfgCode  = 1'b1;

  logic [19:0]        total_q;
  logic [23:0]        code_q;
  logic [2:0]         left_q, left_d;
  logic [7:0]         cur_op_q, cur_op_d;
  logic [31:0]        accum_q, accum_d;
  logic [7:0]         prev_op_q, prev_op_d;
  logic [31:0]        prev_val_q, prev_val_d;
  logic signed [15:0] depth_q, depth_d;
  logic [19:0]        count_q, count_d;
  logic [23:0]        offset_q, offset_d;
  logic               halted_q, halted_d;

  logic               done;
  logic [7:0]         done_op;
  logic [31:0]        done_val;
  logic [2:0]         len;
  logic [1:0]         pos;
  logic [25:0]        end_pos;
  logic signed [16:0] depth_sum;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      code_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTotal: total_q <= cfg_data_i[19:0];
        CfgCode:  code_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Decode of the byte held in the input register.
  always_comb begin
    left_d      = left_q;
    cur_op_d    = cur_op_q;
    accum_d     = accum_q;
    prev_op_d   = prev_op_q;
    prev_val_d  = prev_val_q;
    depth_d     = depth_q;
    count_d     = count_q;
    offset_d    = offset_q;
    halted_d    = halted_q;
    done        = 1'b0;
    done_op     = byte_i;
    done_val    = '0;
    res_valid_o = 1'b0;
    len         = imm_len(left_q != 3'd0 ? cur_op_q : byte_i);
    pos         = 2'(len - left_q);
    end_pos     = {2'b00, offset_q} + 26'd1 + {23'd0, len};
    depth_sum   = '0;

    res_o.opcode       = byte_i;
    res_o.imm_value    = '0;
    res_o.depth_before = depth_q;
    res_o.instr_index  = count_q;
    res_o.status       = StOk;
    res_o.final_res    = 1'b1;

    if (valid_i && !halted_q) begin
      if (left_q != 3'd0) begin
        // Gather one little-endian immediate byte.
        accum_d  = accum_q | ({24'd0, byte_i} << {pos, 3'b000});
        left_d   = left_q - 3'd1;
        offset_d = offset_q + 24'd1;
        if (left_q == 3'd1) begin
          done     = 1'b1;
          done_op  = cur_op_q;
          done_val = accum_d;
        end
      end else if (count_q < total_q) begin
        // Opcode position: check the opcode and the code bound.
        if (byte_i >= OpcodeCount) begin
          res_valid_o  = 1'b1;
          res_o.status = StBadOp;
          halted_d     = 1'b1;
        end else if (end_pos > {2'b00, code_q}) begin
          res_valid_o  = 1'b1;
          res_o.status = StPastEnd;
          halted_d     = 1'b1;
        end else begin
          offset_d = offset_q + 24'd1;
          if (len == 3'd0) begin
            done = 1'b1;
          end else begin
            cur_op_d = byte_i;
            accum_d  = '0;
            left_d   = len;
          end
        end
      end
    end

    // A finished instruction updates depth, history and count.
    if (done) begin
      if (done_op == OpcJump && prev_op_q == OpcConst) begin
        done_val = prev_val_q;
      end
      depth_sum = {depth_q[15], depth_q} + 17'(stack_delta(done_op));
      if (depth_sum > 17'sd32767) begin
        depth_d = 16'sh7fff;
      end else if (depth_sum < -17'sd32768) begin
        depth_d = 16'sh8000;
      end else begin
        depth_d = depth_sum[15:0];
      end
      prev_op_d       = done_op;
      prev_val_d      = done_val;
      count_d         = count_q + 20'd1;
      res_valid_o     = 1'b1;
      res_o.opcode    = done_op;
      res_o.imm_value = done_val;
      res_o.final_res = count_d >= total_q;
    end
  end

  // Decoder state commits only when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      cur_op_q   <= '0;
      accum_q    <= '0;
      prev_op_q  <= '0;
      prev_val_q <= '0;
      depth_q    <= '0;
      count_q    <= '0;
      offset_q   <= '0;
      halted_q   <= 1'b0;
    end else if (adv_i) begin
      left_q     <= left_d;
      cur_op_q   <= cur_op_d;
      accum_q    <= accum_d;
      prev_op_q  <= prev_op_d;
      prev_val_q <= prev_val_d;
      depth_q    <= depth_d;
      count_q    <= count_d;
      offset_q   <= offset_d;
      halted_q   <= halted_d;
    end
  end

  // Checks on the decoder state.
  `BID_ASSERT(a_halt_quiet, !(halted_q && res_valid_o), "result produced while halted")
  `BID_ASSERT(a_left_range, left_q <= 3'd4, "immediate byte count out of range")
  `BID_ASSERT(a_err_final, !(res_valid_o && res_o.status != StOk) || halted_d, "error without halt")
  `BID_ASSERT_NEXT(a_count_step, adv_i && res_valid_o && res_o.status == StOk,
    count_q == 20'($past(count_q) + 20'd1), "instruction count did not advance")

endmodule

// ===== rtl/core/bid_out_reg.sv =====
module bid_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 res_valid_i,
  input  bid_pkg::bid_result_t res_i,
  input  logic                 ready_i,
  output logic                 adv_o,
  output logic                 valid_o,
  output bid_pkg::bid_result_t res_o
);
  import bid_pkg::*;

  logic        valid_q, valid_d;
  bid_result_t res_q;

  // Decode may advance when the result slot is empty or being taken.
  assign adv_o = in_valid_i && (!valid_q || ready_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = res_valid_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
